[hw/rtl/ssd_pkg.sv]
// Package for the segment-to-segment distance pipeline.
// Holds the field widths, internal datapath widths and the quotient kind codes.
// No dependencies.
package ssd_pkg;

    localparam int CoordW    = 16;
    localparam int FracBits  = 8;
    localparam int DiffW     = CoordW + 1;
    localparam int DotW      = 2 * DiffW + 2;
    localparam int WideW     = 2 * DotW;
    localparam int ParamFrac = 32;
    localparam int ParamW    = ParamFrac + 1;
    localparam int CompW     = 52;
    localparam int LoW       = 26;
    localparam int HiW       = CompW - LoW;
    localparam int SqW       = 104;
    localparam int RootIn    = 36;
    localparam int RootW     = 19;
    localparam int OutW      = 18;
    localparam int LimW      = 40;
    localparam int DivSteps  = ParamFrac;
    localparam int Stages    = 64;

    localparam logic [LimW-1:0] LimReset = 40'd42949673;
    localparam logic [OutW-1:0] OutMax   = 18'd262143;

    typedef enum logic [1:0] {
        Q_DIV  = 2'd0,
        Q_ZERO = 2'd1,
        Q_ONE  = 2'd2
    } t_qkind;

endpackage

[hw/rtl/segment_segment_distance.sv]
// Shortest distance between two 3-D segments: a 64-stage pipeline.
// Depends on ssd_pkg for widths and the quotient kind codes.
// The result strobe is the start strobe carried down the valid pipeline beside the data.
// Throughput: one segment pair per cycle; busy is never asserted.
// The two parameter dividers take one quotient bit per stage and the root one bit per stage.
// Reset clears the valid pipeline and loads the threshold with its default; no clearing pass.
module segment_segment_distance (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s1_from_x,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s1_from_y,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s1_from_z,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s1_to_x,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s1_to_y,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s1_to_z,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s2_from_x,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s2_from_y,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s2_from_z,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s2_to_x,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s2_to_y,
    input  logic signed [ssd_pkg::CoordW-1:0] i_s2_to_z,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssd_pkg::LimW-1:0]        i_cfg_data,
    output logic                            o_done,
    output logic [ssd_pkg::OutW-1:0]        o_closest_distance
);

    localparam int DiffW  = ssd_pkg::DiffW;
    localparam int DotW   = ssd_pkg::DotW;
    localparam int WideW  = ssd_pkg::WideW;
    localparam int CompW  = ssd_pkg::CompW;
    localparam int SqW    = ssd_pkg::SqW;
    localparam int RootW  = ssd_pkg::RootW;
    localparam int ParamW = ssd_pkg::ParamW;
    localparam int PF     = ssd_pkg::ParamFrac;
    localparam int NDiv   = ssd_pkg::DivSteps;
    localparam int Sh     = 2 * ssd_pkg::FracBits;

    function automatic logic signed [DotW-1:0] mul_d(input logic signed [DiffW-1:0] x,
                                                     input logic signed [DiffW-1:0] y);
        logic signed [DotW-1:0] xe;
        logic signed [DotW-1:0] ye;
        xe = DotW'(x);
        ye = DotW'(y);
        return xe * ye;
    endfunction

    function automatic logic signed [WideW-1:0] mul_w(input logic signed [DotW-1:0] x,
                                                      input logic signed [DotW-1:0] y);
        logic signed [WideW-1:0] xe;
        logic signed [WideW-1:0] ye;
        xe = WideW'(x);
        ye = WideW'(y);
        return xe * ye;
    endfunction

    function automatic logic signed [WideW-1:0] ext_sh(input logic signed [DotW:0] x);
        logic signed [WideW-1:0] xe;
        xe = WideW'(x);
        return xe <<< Sh;
    endfunction

    function automatic logic signed [CompW-1:0] mul_c(input logic [ParamW-1:0] p,
                                                      input logic signed [DiffW-1:0] x);
        logic signed [CompW-1:0] pe;
        logic signed [CompW-1:0] xe;
        pe = signed'(CompW'(p));
        xe = CompW'(x);
        return pe * xe;
    endfunction

    function automatic ssd_pkg::t_qkind kind_of(input logic signed [WideW-1:0] n,
                                                input logic signed [WideW-1:0] d,
                                                input logic signed [WideW-1:0] lim);
        logic signed [WideW-1:0] mag;
        mag = n[WideW-1] ? -n : n;
        if (mag < lim || d <= 0 || n <= 0) begin
            return ssd_pkg::Q_ZERO;
        end else if (n >= d) begin
            return ssd_pkg::Q_ONE;
        end else begin
            return ssd_pkg::Q_DIV;
        end
    endfunction

    function automatic logic [ParamW-1:0] param_of(input ssd_pkg::t_qkind k,
                                                   input logic [PF-1:0] q);
        case (k)
            ssd_pkg::Q_ONE:  return ParamW'(1) << PF;
            ssd_pkg::Q_ZERO: return '0;
            default:         return {1'b0, q};
        endcase
    endfunction

    logic [ssd_pkg::LimW-1:0]    r_lim;
    logic [ssd_pkg::Stages-1:0]  r_vld;
    logic signed [WideW-1:0]     c_lim;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign c_lim       = signed'(WideW'(r_lim));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= ssd_pkg::LimReset;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_lim <= i_cfg_data;
            end
            r_vld <= {r_vld[ssd_pkg::Stages-2:0], i_start};
        end
    end

    // Stage 1: direction and offset vectors.
    logic signed [ssd_pkg::CoordW-1:0] c_p0 [3];
    logic signed [ssd_pkg::CoordW-1:0] c_p1 [3];
    logic signed [ssd_pkg::CoordW-1:0] c_q0 [3];
    logic signed [ssd_pkg::CoordW-1:0] c_q1 [3];
    logic signed [DiffW-1:0] r1_u [3];
    logic signed [DiffW-1:0] r1_v [3];
    logic signed [DiffW-1:0] r1_w [3];

    assign c_p0[0] = i_s1_from_x;
    assign c_p0[1] = i_s1_from_y;
    assign c_p0[2] = i_s1_from_z;
    assign c_p1[0] = i_s1_to_x;
    assign c_p1[1] = i_s1_to_y;
    assign c_p1[2] = i_s1_to_z;
    assign c_q0[0] = i_s2_from_x;
    assign c_q0[1] = i_s2_from_y;
    assign c_q0[2] = i_s2_from_z;
    assign c_q1[0] = i_s2_to_x;
    assign c_q1[1] = i_s2_to_y;
    assign c_q1[2] = i_s2_to_z;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_u[i] <= DiffW'(c_p1[i]) - DiffW'(c_p0[i]);
            r1_v[i] <= DiffW'(c_q1[i]) - DiffW'(c_q0[i]);
            r1_w[i] <= DiffW'(c_p0[i]) - DiffW'(c_q0[i]);
        end
    end

    // Stage 2: dot products.
    logic signed [DotW-1:0] r2_a, r2_b, r2_c, r2_d, r2_e;
    logic signed [DiffW-1:0] r2_u [3];
    logic signed [DiffW-1:0] r2_v [3];
    logic signed [DiffW-1:0] r2_w [3];

    always_ff @(posedge i_clk) begin
        r2_a <= mul_d(r1_u[0], r1_u[0]) + mul_d(r1_u[1], r1_u[1]) + mul_d(r1_u[2], r1_u[2]);
        r2_b <= mul_d(r1_u[0], r1_v[0]) + mul_d(r1_u[1], r1_v[1]) + mul_d(r1_u[2], r1_v[2]);
        r2_c <= mul_d(r1_v[0], r1_v[0]) + mul_d(r1_v[1], r1_v[1]) + mul_d(r1_v[2], r1_v[2]);
        r2_d <= mul_d(r1_u[0], r1_w[0]) + mul_d(r1_u[1], r1_w[1]) + mul_d(r1_u[2], r1_w[2]);
        r2_e <= mul_d(r1_v[0], r1_w[0]) + mul_d(r1_v[1], r1_w[1]) + mul_d(r1_v[2], r1_w[2]);
        r2_u <= r1_u;
        r2_v <= r1_v;
        r2_w <= r1_w;
    end

    // Stage 3: cross products of the dot products.
    logic signed [WideW-1:0] r3_ac, r3_bb, r3_be, r3_cd, r3_ae, r3_bd;
    logic signed [DotW-1:0]  r3_a, r3_b, r3_c, r3_d, r3_e;
    logic signed [DiffW-1:0] r3_u [3];
    logic signed [DiffW-1:0] r3_v [3];
    logic signed [DiffW-1:0] r3_w [3];

    always_ff @(posedge i_clk) begin
        r3_ac <= mul_w(r2_a, r2_c);
        r3_bb <= mul_w(r2_b, r2_b);
        r3_be <= mul_w(r2_b, r2_e);
        r3_cd <= mul_w(r2_c, r2_d);
        r3_ae <= mul_w(r2_a, r2_e);
        r3_bd <= mul_w(r2_b, r2_d);
        r3_a  <= r2_a;
        r3_b  <= r2_b;
        r3_c  <= r2_c;
        r3_d  <= r2_d;
        r3_e  <= r2_e;
        r3_u  <= r2_u;
        r3_v  <= r2_v;
        r3_w  <= r2_w;
    end

    // Stage 4: determinant and unclamped numerators.
    logic signed [WideW-1:0] r4_dt, r4_sn, r4_tn;
    logic signed [DotW-1:0]  r4_a, r4_b, r4_c, r4_d, r4_e;
    logic signed [DiffW-1:0] r4_u [3];
    logic signed [DiffW-1:0] r4_v [3];
    logic signed [DiffW-1:0] r4_w [3];

    always_ff @(posedge i_clk) begin
        r4_dt <= r3_ac - r3_bb;
        r4_sn <= r3_be - r3_cd;
        r4_tn <= r3_ae - r3_bd;
        r4_a  <= r3_a;
        r4_b  <= r3_b;
        r4_c  <= r3_c;
        r4_d  <= r3_d;
        r4_e  <= r3_e;
        r4_u  <= r3_u;
        r4_v  <= r3_v;
        r4_w  <= r3_w;
    end

    // Stage 5: parallel case and clamping of the first parameter.
    logic signed [WideW-1:0] n5_sn, n5_sd, n5_tn, n5_td;
    logic signed [WideW-1:0] r5_sn, r5_sd, r5_tn, r5_td;
    logic signed [DotW-1:0]  r5_a, r5_b, r5_d;
    logic signed [DiffW-1:0] r5_u [3];
    logic signed [DiffW-1:0] r5_v [3];
    logic signed [DiffW-1:0] r5_w [3];

    always_comb begin
        if (r4_dt < c_lim) begin
            n5_sn = '0;
            n5_sd = WideW'(1) <<< (2 * Sh);
            n5_tn = ext_sh((DotW + 1)'(r4_e));
            n5_td = ext_sh((DotW + 1)'(r4_c));
        end else if (r4_sn[WideW-1]) begin
            n5_sn = '0;
            n5_sd = r4_dt;
            n5_tn = ext_sh((DotW + 1)'(r4_e));
            n5_td = ext_sh((DotW + 1)'(r4_c));
        end else if (r4_sn > r4_dt) begin
            n5_sn = r4_dt;
            n5_sd = r4_dt;
            n5_tn = ext_sh((DotW + 1)'(r4_e) + (DotW + 1)'(r4_b));
            n5_td = ext_sh((DotW + 1)'(r4_c));
        end else begin
            n5_sn = r4_sn;
            n5_sd = r4_dt;
            n5_tn = r4_tn;
            n5_td = r4_dt;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_sn <= n5_sn;
        r5_sd <= n5_sd;
        r5_tn <= n5_tn;
        r5_td <= n5_td;
        r5_a  <= r4_a;
        r5_b  <= r4_b;
        r5_d  <= r4_d;
        r5_u  <= r4_u;
        r5_v  <= r4_v;
        r5_w  <= r4_w;
    end

    // Stage 6: clamping of the second parameter and recompute of the first.
    logic signed [WideW-1:0] n6_sn, n6_sd, n6_tn;
    logic signed [WideW-1:0] c6_edge, c6_a;
    logic                    c6_tneg;
    logic signed [WideW-1:0] r6_sn, r6_sd, r6_tn, r6_td;
    logic signed [DiffW-1:0] r6_u [3];
    logic signed [DiffW-1:0] r6_v [3];
    logic signed [DiffW-1:0] r6_w [3];

    always_comb begin
        c6_tneg = r5_tn[WideW-1];
        c6_a    = WideW'(r5_a);
        c6_edge = c6_tneg ? -WideW'(r5_d) : WideW'(r5_b) - WideW'(r5_d);
        n6_sn   = r5_sn;
        n6_sd   = r5_sd;
        n6_tn   = r5_tn;
        if (c6_tneg || r5_tn > r5_td) begin
            n6_tn = c6_tneg ? '0 : r5_td;
            if (c6_edge[WideW-1]) begin
                n6_sn = '0;
            end else if (c6_edge > c6_a) begin
                n6_sn = r5_sd;
            end else begin
                n6_sn = c6_edge <<< Sh;
                n6_sd = c6_a <<< Sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r6_sn <= n6_sn;
        r6_sd <= n6_sd;
        r6_tn <= n6_tn;
        r6_td <= r5_td;
        r6_u  <= r5_u;
        r6_v  <= r5_v;
        r6_w  <= r5_w;
    end

    // Stage 7 and the divider stages: restoring division, one quotient bit per stage.
    logic [WideW-1:0]        r_sn [NDiv+1];
    logic [WideW-1:0]        r_sd [NDiv+1];
    logic [PF-1:0]           r_sq [NDiv+1];
    ssd_pkg::t_qkind         r_sk [NDiv+1];
    logic [WideW-1:0]        r_tn [NDiv+1];
    logic [WideW-1:0]        r_td [NDiv+1];
    logic [PF-1:0]           r_tq [NDiv+1];
    ssd_pkg::t_qkind         r_tk [NDiv+1];
    logic signed [DiffW-1:0] r_du [NDiv+1][3];
    logic signed [DiffW-1:0] r_dv [NDiv+1][3];
    logic signed [DiffW-1:0] r_dw [NDiv+1][3];

    always_ff @(posedge i_clk) begin
        r_sn[0] <= unsigned'(r6_sn);
        r_sd[0] <= unsigned'(r6_sd);
        r_sq[0] <= '0;
        r_sk[0] <= kind_of(r6_sn, r6_sd, c_lim);
        r_tn[0] <= unsigned'(r6_tn);
        r_td[0] <= unsigned'(r6_td);
        r_tq[0] <= '0;
        r_tk[0] <= kind_of(r6_tn, r6_td, c_lim);
        r_du[0] <= r6_u;
        r_dv[0] <= r6_v;
        r_dw[0] <= r6_w;
    end

    for (genvar k = 0; k < NDiv; k++) begin : g_div
        logic [WideW-1:0] n_s2, n_t2;
        assign n_s2 = {r_sn[k][WideW-2:0], 1'b0};
        assign n_t2 = {r_tn[k][WideW-2:0], 1'b0};
        always_ff @(posedge i_clk) begin
            if (n_s2 >= r_sd[k]) begin
                r_sn[k+1] <= n_s2 - r_sd[k];
                r_sq[k+1] <= {r_sq[k][PF-2:0], 1'b1};
            end else begin
                r_sn[k+1] <= n_s2;
                r_sq[k+1] <= {r_sq[k][PF-2:0], 1'b0};
            end
            if (n_t2 >= r_td[k]) begin
                r_tn[k+1] <= n_t2 - r_td[k];
                r_tq[k+1] <= {r_tq[k][PF-2:0], 1'b1};
            end else begin
                r_tn[k+1] <= n_t2;
                r_tq[k+1] <= {r_tq[k][PF-2:0], 1'b0};
            end
            r_sd[k+1] <= r_sd[k];
            r_td[k+1] <= r_td[k];
            r_sk[k+1] <= r_sk[k];
            r_tk[k+1] <= r_tk[k];
            r_du[k+1] <= r_du[k];
            r_dv[k+1] <= r_dv[k];
            r_dw[k+1] <= r_dw[k];
        end
    end

    // Scaled direction vectors, difference vector, square partial products and sums.
    logic [ParamW-1:0]                         c_sc, c_tc;
    logic signed [CompW-1:0]                   r7_su [3];
    logic signed [CompW-1:0]                   r7_tv [3];
    logic signed [DiffW-1:0]                   r7_w [3];
    logic signed [CompW-1:0]                   r8_cp [3];
    logic signed [2*ssd_pkg::HiW-1:0]          r9_hh [3];
    logic signed [ssd_pkg::HiW+ssd_pkg::LoW:0] r9_hl [3];
    logic [2*ssd_pkg::LoW-1:0]                 r9_ll [3];
    logic signed [SqW-1:0]                     r10_sq [3];
    logic [SqW-1:0]                            n11_sum;
    logic [ssd_pkg::RootIn-1:0]                r11_x;
    logic                                      r11_sat;

    assign c_sc = param_of(r_sk[NDiv], r_sq[NDiv]);
    assign c_tc = param_of(r_tk[NDiv], r_tq[NDiv]);
    assign n11_sum = unsigned'(r10_sq[0] + r10_sq[1] + r10_sq[2]);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r7_su[i] <= mul_c(c_sc, r_du[NDiv][i]);
            r7_tv[i] <= mul_c(c_tc, r_dv[NDiv][i]);
            r7_w[i]  <= r_dw[NDiv][i];
            r8_cp[i] <= (CompW'(r7_w[i]) <<< PF) + r7_su[i] - r7_tv[i];
            r9_hh[i] <= (2 * ssd_pkg::HiW)'(signed'(r8_cp[i][CompW-1:ssd_pkg::LoW]))
                      * (2 * ssd_pkg::HiW)'(signed'(r8_cp[i][CompW-1:ssd_pkg::LoW]));
            r9_hl[i] <= (ssd_pkg::HiW + ssd_pkg::LoW + 1)'(
                            signed'(r8_cp[i][CompW-1:ssd_pkg::LoW]))
                      * (ssd_pkg::HiW + ssd_pkg::LoW + 1)'(
                            signed'({1'b0, r8_cp[i][ssd_pkg::LoW-1:0]}));
            r9_ll[i] <= (2 * ssd_pkg::LoW)'(r8_cp[i][ssd_pkg::LoW-1:0])
                      * (2 * ssd_pkg::LoW)'(r8_cp[i][ssd_pkg::LoW-1:0]);
            r10_sq[i] <= (SqW'(r9_hh[i]) <<< (2 * ssd_pkg::LoW))
                       + (SqW'(r9_hl[i]) <<< (ssd_pkg::LoW + 1))
                       + signed'(SqW'(r9_ll[i]));
        end
        r11_x   <= n11_sum[2*PF+ssd_pkg::RootIn-1:2*PF];
        r11_sat <= |n11_sum[SqW-1:2*PF+ssd_pkg::RootIn];
    end

    // Square root, one result bit per stage, tracking the running square.
    logic [RootW-1:0]           r_rt [RootW+1];
    logic [2*RootW-1:0]         r_r2 [RootW+1];
    logic [ssd_pkg::RootIn-1:0] r_rx [RootW+1];
    logic                       r_rs [RootW+1];

    assign r_rt[0] = '0;
    assign r_r2[0] = '0;
    assign r_rx[0] = r11_x;
    assign r_rs[0] = r11_sat;

    for (genvar k = 0; k < RootW; k++) begin : g_root
        localparam int Bit = RootW - 1 - k;
        logic [2*RootW+1:0] n_cand;
        assign n_cand = (2*RootW+2)'(r_r2[k])
                      + ((2*RootW+2)'(r_rt[k]) << (Bit + 1))
                      + ((2*RootW+2)'(1) << (2 * Bit));
        always_ff @(posedge i_clk) begin
            if (n_cand <= (2*RootW+2)'(r_rx[k])) begin
                r_rt[k+1] <= r_rt[k] | (RootW'(1) << Bit);
                r_r2[k+1] <= n_cand[2*RootW-1:0];
            end else begin
                r_rt[k+1] <= r_rt[k];
                r_r2[k+1] <= r_r2[k];
            end
            r_rx[k+1] <= r_rx[k];
            r_rs[k+1] <= r_rs[k];
        end
    end

    logic [ssd_pkg::OutW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (r_rs[RootW] || r_rt[RootW] > RootW'(ssd_pkg::OutMax)) begin
            r_out <= ssd_pkg::OutMax;
        end else begin
            r_out <= r_rt[RootW][ssd_pkg::OutW-1:0];
        end
    end

    assign o_done             = r_vld[ssd_pkg::Stages-1];
    assign o_closest_distance = r_out;

endmodule
